[design/cae_pkg.sv]
// ----------------------------------------------------------------------------
// cae_pkg
// Shared types, sizes and codes of the cigar alignment event expander.
// ----------------------------------------------------------------------------
package cae_pkg;

  // sizes
  localparam int REF_DEPTH     = 4096;
  localparam int QUERY_DEPTH   = 1024;
  localparam int MAX_OP_LENGTH = 63;
  localparam int POS_BITS      = 16;
  localparam int REF_AW        = $clog2(REF_DEPTH);
  localparam int QRY_AW        = $clog2(QUERY_DEPTH);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [REF_AW-1:0]   ref_addr_t;
  typedef logic [QRY_AW-1:0]   qry_addr_t;
  typedef logic [15:0]         len_t;
  typedef logic [5:0]          oplen_t;

  // request types
  localparam logic [2:0] REQ_LDREF  = 3'd0;
  localparam logic [2:0] REQ_LDQRY  = 3'd1;
  localparam logic [2:0] REQ_START  = 3'd2;
  localparam logic [2:0] REQ_OP     = 3'd3;
  localparam logic [2:0] REQ_FINISH = 3'd4;

  // cigar operation codes
  localparam logic [3:0] OP_M  = 4'd0;
  localparam logic [3:0] OP_I  = 4'd1;
  localparam logic [3:0] OP_D  = 4'd2;
  localparam logic [3:0] OP_N  = 4'd3;
  localparam logic [3:0] OP_S  = 4'd4;
  localparam logic [3:0] OP_H  = 4'd5;
  localparam logic [3:0] OP_P  = 4'd6;
  localparam logic [3:0] OP_EQ = 4'd7;
  localparam logic [3:0] OP_X  = 4'd8;

  // event types
  localparam logic [1:0] EV_MATCH    = 2'd0;
  localparam logic [1:0] EV_MISMATCH = 2'd1;
  localparam logic [1:0] EV_INS      = 2'd2;
  localparam logic [1:0] EV_DEL      = 2'd3;

  // command classes handed from front to back
  localparam logic [3:0] CLS_LDREF  = 4'd0;
  localparam logic [3:0] CLS_LDQRY  = 4'd1;
  localparam logic [3:0] CLS_START  = 4'd2;
  localparam logic [3:0] CLS_FINISH = 4'd3;
  localparam logic [3:0] CLS_CMP    = 4'd4;
  localparam logic [3:0] CLS_INS    = 4'd5;
  localparam logic [3:0] CLS_DEL    = 4'd6;
  localparam logic [3:0] CLS_ADVREF = 4'd7;
  localparam logic [3:0] CLS_ADVSEQ = 4'd8;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] addr;
    logic [7:0]  base;
    logic [11:0] ref_offset;
    logic [3:0]  op_code;
    logic [5:0]  op_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_type;
    logic [15:0] event_length;
    logic [15:0] ref_pos;
    logic [15:0] seq_pos;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  cls;
    logic [11:0] addr;
    logic [7:0]  base;
    logic [11:0] ref_offset;
    oplen_t      length;
  } cmd_t;

endpackage

[design/cae_ram.sv]
// ----------------------------------------------------------------------------
// cae_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module cae_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/cae_front.sv]
// ----------------------------------------------------------------------------
// cae_front
// Decodes an incoming item into a command class, clamps the operation
// length and drops items that have no effect.
// ----------------------------------------------------------------------------
module cae_front (
  input  cae_pkg::in_item_t request,
  output cae_pkg::cmd_t     cmd,
  output logic              keep
);

  cae_pkg::oplen_t len;

  // length clamp
  always_comb begin
    if (request.op_length > cae_pkg::oplen_t'(cae_pkg::MAX_OP_LENGTH)) begin
      len = cae_pkg::oplen_t'(cae_pkg::MAX_OP_LENGTH);
    end else begin
      len = request.op_length;
    end
  end

  // classify
  always_comb begin
    cmd.addr       = request.addr;
    cmd.base       = request.base;
    cmd.ref_offset = request.ref_offset;
    cmd.length     = len;
    cmd.cls        = cae_pkg::CLS_LDREF;
    keep           = 1'b0;
    case (request.req_type)
      cae_pkg::REQ_LDREF: begin
        cmd.cls = cae_pkg::CLS_LDREF;
        keep    = 1'b1;
      end
      cae_pkg::REQ_LDQRY: begin
        cmd.cls = cae_pkg::CLS_LDQRY;
        keep    = 1'b1;
      end
      cae_pkg::REQ_START: begin
        cmd.cls = cae_pkg::CLS_START;
        keep    = 1'b1;
      end
      cae_pkg::REQ_FINISH: begin
        cmd.cls = cae_pkg::CLS_FINISH;
        keep    = 1'b1;
      end
      cae_pkg::REQ_OP: begin
        // zero length and hard clip / padding change nothing
        if (len != '0) begin
          if (request.op_code inside {cae_pkg::OP_M, cae_pkg::OP_EQ, cae_pkg::OP_X}) begin
            cmd.cls = cae_pkg::CLS_CMP;
            keep    = 1'b1;
          end else begin
            case (request.op_code)
              cae_pkg::OP_I: begin
                cmd.cls = cae_pkg::CLS_INS;
                keep    = 1'b1;
              end
              cae_pkg::OP_D: begin
                cmd.cls = cae_pkg::CLS_DEL;
                keep    = 1'b1;
              end
              cae_pkg::OP_N: begin
                cmd.cls = cae_pkg::CLS_ADVREF;
                keep    = 1'b1;
              end
              cae_pkg::OP_S: begin
                cmd.cls = cae_pkg::CLS_ADVSEQ;
                keep    = 1'b1;
              end
              default: keep = 1'b0;
            endcase
          end
        end
      end
      default: keep = 1'b0;
    endcase
  end

endmodule

[design/cae_queue.sv]
// ----------------------------------------------------------------------------
// cae_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module cae_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cae_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output cae_pkg::cmd_t head
);

  cae_pkg::cmd_t                  entries [cae_pkg::QUEUE_DEPTH];
  logic [cae_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [cae_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [cae_pkg::QUEUE_AW:0]     count;

  assign full       = (count == (cae_pkg::QUEUE_AW+1)'(cae_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

[design/cae_back.sv]
// ----------------------------------------------------------------------------
// cae_back
// Executes commands: base stores, cursors, event merging and result output.
// ----------------------------------------------------------------------------
module cae_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cae_pkg::cmd_t      head,
  output logic               pop,
  output logic               result_valid,
  output cae_pkg::out_item_t result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]          state, state_next;
  logic [11:0]         offset_reg, offset_reg_next;
  cae_pkg::pos_t       ref_cursor, ref_cursor_next;
  cae_pkg::pos_t       seq_cursor, seq_cursor_next;
  logic                pend_valid, pend_valid_next;
  logic [1:0]          pend_type, pend_type_next;
  cae_pkg::len_t       pend_length, pend_length_next;
  cae_pkg::pos_t       pend_ref, pend_ref_next;
  cae_pkg::pos_t       pend_seq, pend_seq_next;
  cae_pkg::oplen_t     count, count_next;
  cae_pkg::ref_addr_t  ref_rptr, ref_rptr_next;
  cae_pkg::qry_addr_t  qry_rptr, qry_rptr_next;
  logic                hold_valid, hold_valid_next;
  cae_pkg::out_item_t  hold, hold_next;
  logic                out_valid_next;
  cae_pkg::out_item_t  out_next;

  logic                ref_we, qry_we;
  cae_pkg::ref_addr_t  ref_raddr;
  cae_pkg::qry_addr_t  qry_raddr;
  logic [7:0]          ref_rdata, qry_rdata;

  logic                ev_do;
  logic [1:0]          ev_type;
  cae_pkg::len_t       ev_len;
  logic [16:0]         len_sum;
  cae_pkg::pos_t       rend, send;
  logic                merge;
  cae_pkg::out_item_t  pend_rec;

  // base stores
  cae_ram #(.WIDTH(8), .DEPTH(cae_pkg::REF_DEPTH)) u_ref_ram (
    .clk   (clk),
    .we    (ref_we),
    .waddr (cae_pkg::ref_addr_t'(head.addr)),
    .wdata (head.base),
    .raddr (ref_raddr),
    .rdata (ref_rdata)
  );

  cae_ram #(.WIDTH(8), .DEPTH(cae_pkg::QUERY_DEPTH)) u_qry_ram (
    .clk   (clk),
    .we    (qry_we),
    .waddr (cae_pkg::qry_addr_t'(head.addr)),
    .wdata (head.base),
    .raddr (qry_raddr),
    .rdata (qry_rdata)
  );

  // merge test against the pending event
  always_comb begin
    len_sum = {1'b0, pend_length} + {1'b0, ev_len};
    rend    = pend_ref + ((ev_type != cae_pkg::EV_INS) ?
                          cae_pkg::pos_t'(pend_length) : '0);
    send    = pend_seq + ((ev_type != cae_pkg::EV_DEL) ?
                          cae_pkg::pos_t'(pend_length) : '0);
    merge   = pend_valid && (pend_type == ev_type) && (rend == ref_cursor) &&
              (send == seq_cursor) && !len_sum[16];
    pend_rec.event_type   = pend_type;
    pend_rec.event_length = pend_length;
    pend_rec.ref_pos      = 16'(pend_ref);
    pend_rec.seq_pos      = 16'(pend_seq);
    pend_rec.last         = 1'b0;
  end

  // sequencer
  always_comb begin
    state_next       = state;
    offset_reg_next  = offset_reg;
    ref_cursor_next  = ref_cursor;
    seq_cursor_next  = seq_cursor;
    pend_valid_next  = pend_valid;
    pend_type_next   = pend_type;
    pend_length_next = pend_length;
    pend_ref_next    = pend_ref;
    pend_seq_next    = pend_seq;
    count_next       = count;
    ref_rptr_next    = ref_rptr;
    qry_rptr_next    = qry_rptr;
    hold_valid_next  = hold_valid;
    hold_next        = hold;
    out_valid_next   = 1'b0;
    out_next         = pend_rec;
    pop              = 1'b0;
    ref_we           = 1'b0;
    qry_we           = 1'b0;
    ref_raddr        = ref_rptr;
    qry_raddr        = qry_rptr;
    ev_do            = 1'b0;
    ev_type          = cae_pkg::EV_MATCH;
    ev_len           = 16'd1;

    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.cls)
            cae_pkg::CLS_LDREF: ref_we = 1'b1;
            cae_pkg::CLS_LDQRY: qry_we = 1'b1;
            cae_pkg::CLS_START: begin
              offset_reg_next  = head.ref_offset;
              ref_cursor_next  = '0;
              seq_cursor_next  = '0;
              pend_valid_next  = 1'b0;
              pend_type_next   = cae_pkg::EV_MATCH;
              pend_length_next = '0;
              pend_ref_next    = '0;
              pend_seq_next    = '0;
            end
            cae_pkg::CLS_FINISH: begin
              if (pend_valid) begin
                out_valid_next   = 1'b1;
                out_next.last    = 1'b1;
                pend_valid_next  = 1'b0;
                pend_type_next   = cae_pkg::EV_MATCH;
                pend_length_next = '0;
                pend_ref_next    = '0;
                pend_seq_next    = '0;
              end
            end
            cae_pkg::CLS_CMP: begin
              // first read addresses, later ones from the read pointers
              ref_raddr     = cae_pkg::ref_addr_t'(offset_reg) +
                              cae_pkg::ref_addr_t'(ref_cursor);
              qry_raddr     = cae_pkg::qry_addr_t'(seq_cursor);
              ref_rptr_next = ref_raddr + 1'b1;
              qry_rptr_next = qry_raddr + 1'b1;
              count_next    = head.length;
              state_next    = ST_CMP;
            end
            cae_pkg::CLS_INS: begin
              ev_do           = 1'b1;
              ev_type         = cae_pkg::EV_INS;
              ev_len          = cae_pkg::len_t'(head.length);
              seq_cursor_next = seq_cursor + cae_pkg::pos_t'(head.length);
            end
            cae_pkg::CLS_DEL: begin
              ev_do           = 1'b1;
              ev_type         = cae_pkg::EV_DEL;
              ev_len          = cae_pkg::len_t'(head.length);
              ref_cursor_next = ref_cursor + cae_pkg::pos_t'(head.length);
            end
            cae_pkg::CLS_ADVREF: ref_cursor_next = ref_cursor + cae_pkg::pos_t'(head.length);
            cae_pkg::CLS_ADVSEQ: seq_cursor_next = seq_cursor + cae_pkg::pos_t'(head.length);
            default: ;
          endcase
        end
      end
      ST_CMP: begin
        // one base pair per cycle
        ev_do           = 1'b1;
        ev_type         = (ref_rdata == qry_rdata) ? cae_pkg::EV_MATCH : cae_pkg::EV_MISMATCH;
        ref_cursor_next = ref_cursor + 1'b1;
        seq_cursor_next = seq_cursor + 1'b1;
        ref_rptr_next   = ref_rptr + 1'b1;
        qry_rptr_next   = qry_rptr + 1'b1;
        count_next      = count - 1'b1;
        if (count == cae_pkg::oplen_t'(1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // the held event is the final result of the item
        if (hold_valid) begin
          out_valid_next  = 1'b1;
          out_next        = hold;
          out_next.last   = 1'b1;
          hold_valid_next = 1'b0;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // merge or replace the pending event
    if (ev_do) begin
      if (merge) begin
        pend_length_next = len_sum[15:0];
      end else begin
        if (pend_valid) begin
          if (state == ST_CMP) begin
            // more events may follow, so park this one
            if (hold_valid) begin
              out_valid_next = 1'b1;
              out_next       = hold;
            end
            hold_next       = pend_rec;
            hold_valid_next = 1'b1;
          end else begin
            out_valid_next = 1'b1;
            out_next.last  = 1'b1;
          end
        end
        pend_valid_next  = 1'b1;
        pend_type_next   = ev_type;
        pend_length_next = ev_len;
        pend_ref_next    = ref_cursor;
        pend_seq_next    = seq_cursor;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      offset_reg   <= '0;
      ref_cursor   <= '0;
      seq_cursor   <= '0;
      pend_valid   <= 1'b0;
      pend_type    <= cae_pkg::EV_MATCH;
      pend_length  <= '0;
      pend_ref     <= '0;
      pend_seq     <= '0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      offset_reg   <= offset_reg_next;
      ref_cursor   <= ref_cursor_next;
      seq_cursor   <= seq_cursor_next;
      pend_valid   <= pend_valid_next;
      pend_type    <= pend_type_next;
      pend_length  <= pend_length_next;
      pend_ref     <= pend_ref_next;
      pend_seq     <= pend_seq_next;
      hold_valid   <= hold_valid_next;
      result_valid <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    count    <= count_next;
    ref_rptr <= ref_rptr_next;
    qry_rptr <= qry_rptr_next;
    hold     <= hold_next;
    result   <= out_next;
  end

endmodule

[design/cigar_alignment_event_expander_core.sv]
// ----------------------------------------------------------------------------
// cigar_alignment_event_expander_core
// Expands binary cigar operations into merged match, mismatch, insertion and
// deletion events, comparing reference and query bases from two stores.
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  --------  ------------------------  ---------------------------------
//  input     start, busy, request      taken when start high, busy low
//  result    result_valid, result      one-cycle strobe, no back-pressure
//
//  An item waits in a two-entry command queue; busy is high while it is full.
//  In the back end a load, start, advance, insertion, deletion or finish item
//  is done in the idle state; an M, = or X item runs through the compare and
//  flush states, one base pair per cycle from the registered store read ports.
//  Results leave through an output register in the cycle after they are formed.
//  Reset clears cursors, pending event and queue; store contents are kept.
//  The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module cigar_alignment_event_expander_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cae_pkg::in_item_t  request,
  output logic               result_valid,
  output cae_pkg::out_item_t result
);

  cae_pkg::cmd_t front_cmd;
  logic          front_keep;
  logic          push;
  logic          pop;
  logic          head_valid;
  cae_pkg::cmd_t head;

  // front: decode
  cae_front u_front (
    .request (request),
    .cmd     (front_cmd),
    .keep    (front_keep)
  );

  assign push = start && !busy && front_keep;

  // command queue
  cae_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (front_cmd),
    .pop        (pop),
    .full       (busy),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: execution
  cae_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result strobe right after reset");

  // every event covers at least one position
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.event_length != 16'd0))
    else $error("zero length event");

  // the queue fills only through an accepted item
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // no pop from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

[tb/sv/cigar_alignment_event_expander_core_tb.sv]
// ----------------------------------------------------------------------------
// cigar_alignment_event_expander_core_tb
// Self-checking bench for the cigar event expander: a queue-fed driver sends
// base loads, alignment starts, cigar operations and finishes with random
// gaps; a monitor expands every accepted item into match, mismatch,
// insertion and deletion events and checks each strobed result in order.
// ----------------------------------------------------------------------------
module cigar_alignment_event_expander_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HALF_PERIOD   = 10;
  localparam int         RESET_CYCLES  = 10;
  localparam int         RANDOM_ITEMS  = 365;
  localparam int         QUIET_LIMIT   = 2000;
  localparam int         TAIL_CYCLES   = 300;
  localparam int         EVENT_LEN_MAX = 65535;
  localparam logic [2:0] REQ_TOP       = 3'd7;
  localparam logic [3:0] OP_LAST       = 4'hF;
  localparam logic [31:0] NUCLEOTIDES  = "ACGT";

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  cae_pkg::in_item_t  request = '0;
  logic               result_valid;
  cae_pkg::out_item_t result;

  cigar_alignment_event_expander_core uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  // clock
  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // items waiting to be sent, events waiting to come back
  cae_pkg::in_item_t  cigar_items[$];
  cae_pkg::out_item_t due_events[$];
  cae_pkg::out_item_t item_events[$];

  int        stim_count;
  int        items_taken;
  int        events_checked;
  int        errors;
  int        ev_count[4];
  int        quiet_cycles;
  bit        took;

  // stimulus-side view of stores and cursors, so compares only read written bases
  logic [7:0]    gen_ref_base[cae_pkg::REF_DEPTH];
  bit            gen_ref_set[cae_pkg::REF_DEPTH];
  logic [7:0]    gen_qry_base[cae_pkg::QUERY_DEPTH];
  bit            gen_qry_set[cae_pkg::QUERY_DEPTH];
  logic [11:0]   gen_off;
  cae_pkg::pos_t gen_rc;
  cae_pkg::pos_t gen_sc;

  // expander state as the monitor sees it
  logic [7:0]    ref_bases[cae_pkg::REF_DEPTH];
  logic [7:0]    qry_bases[cae_pkg::QUERY_DEPTH];
  logic [11:0]   align_off;
  cae_pkg::pos_t ref_cur;
  cae_pkg::pos_t seq_cur;
  bit            open_valid;
  logic [1:0]    open_type;
  int unsigned   open_len;
  cae_pkg::pos_t open_ref;
  cae_pkg::pos_t open_seq;

  function automatic cae_pkg::in_item_t random_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return cae_pkg::in_item_t'(r[$bits(cae_pkg::in_item_t)-1:0]);
  endfunction

  // mostly nucleotide letters so that matches are common
  function automatic logic [7:0] pick_base();
    if ($urandom_range(99) < 85) return NUCLEOTIDES[8*$urandom_range(3) +: 8];
    return 8'($urandom_range(255));
  endfunction

  function automatic void queue_item(cae_pkg::in_item_t it);
    cigar_items = {cigar_items, it};
    if (it.req_type <= cae_pkg::REQ_FINISH) stim_count++;
  endfunction

  function automatic void gen_load_ref(logic [11:0] addr, logic [7:0] base);
    cae_pkg::in_item_t it;
    it = random_item();
    it.req_type = cae_pkg::REQ_LDREF;
    it.addr = addr;
    it.base = base;
    gen_ref_base[cae_pkg::ref_addr_t'(addr)] = base;
    gen_ref_set[cae_pkg::ref_addr_t'(addr)] = 1'b1;
    queue_item(it);
  endfunction

  function automatic void gen_load_qry(logic [11:0] addr, logic [7:0] base);
    cae_pkg::in_item_t it;
    it = random_item();
    it.req_type = cae_pkg::REQ_LDQRY;
    it.addr = addr;
    it.base = base;
    gen_qry_base[cae_pkg::qry_addr_t'(addr)] = base;
    gen_qry_set[cae_pkg::qry_addr_t'(addr)] = 1'b1;
    queue_item(it);
  endfunction

  function automatic void gen_start(logic [11:0] off);
    cae_pkg::in_item_t it;
    it = random_item();
    it.req_type = cae_pkg::REQ_START;
    it.ref_offset = off;
    gen_off = off;
    gen_rc = '0;
    gen_sc = '0;
    queue_item(it);
  endfunction

  function automatic void gen_finish();
    cae_pkg::in_item_t it;
    it = random_item();
    it.req_type = cae_pkg::REQ_FINISH;
    queue_item(it);
  endfunction

  // one cigar operation, preceded by the base loads that its compares need
  function automatic void gen_op(logic [3:0] code, int len);
    cae_pkg::in_item_t  it;
    cae_pkg::ref_addr_t ra;
    cae_pkg::qry_addr_t qa;
    int                 i;
    if (len != 0 && (code == cae_pkg::OP_M || code == cae_pkg::OP_EQ ||
                     code == cae_pkg::OP_X)) begin
      for (i = 0; i < len; i++) begin
        ra = cae_pkg::ref_addr_t'(gen_off + gen_rc + cae_pkg::pos_t'(i));
        qa = cae_pkg::qry_addr_t'(gen_sc + cae_pkg::pos_t'(i));
        if (!gen_ref_set[ra]) gen_load_ref(12'(ra), pick_base());
        if (!gen_qry_set[qa] || $urandom_range(99) < 25)
          gen_load_qry({2'($urandom_range(3)), qa},
                       ($urandom_range(99) < 70) ? gen_ref_base[ra] : pick_base());
      end
    end
    it = random_item();
    it.req_type = cae_pkg::REQ_OP;
    it.op_code = code;
    it.op_length = 6'(len);
    queue_item(it);
    if (len != 0) begin
      case (code)
        cae_pkg::OP_M, cae_pkg::OP_EQ, cae_pkg::OP_X: begin
          gen_rc += cae_pkg::pos_t'(len);
          gen_sc += cae_pkg::pos_t'(len);
        end
        cae_pkg::OP_I, cae_pkg::OP_S: gen_sc += cae_pkg::pos_t'(len);
        cae_pkg::OP_D, cae_pkg::OP_N: gen_rc += cae_pkg::pos_t'(len);
        default: ;
      endcase
    end
  endfunction

  // move the open event to this item's output list
  function automatic void flush_open();
    cae_pkg::out_item_t ev;
    ev.event_type = open_type;
    ev.event_length = 16'(open_len);
    ev.ref_pos = open_ref;
    ev.seq_pos = open_seq;
    ev.last = 1'b0;
    item_events = {item_events, ev};
    open_valid = 1'b0;
  endfunction

  // merge into the open event when contiguous and short enough, else replace it
  function automatic void note_event(logic [1:0] ty, int len, cae_pkg::pos_t r,
                                     cae_pkg::pos_t s);
    cae_pkg::pos_t rend, send;
    rend = open_ref + ((ty != cae_pkg::EV_INS) ? cae_pkg::pos_t'(open_len) :
                                                 cae_pkg::pos_t'(0));
    send = open_seq + ((ty != cae_pkg::EV_DEL) ? cae_pkg::pos_t'(open_len) :
                                                 cae_pkg::pos_t'(0));
    if (open_valid && open_type == ty && rend == r && send == s &&
        open_len + len <= EVENT_LEN_MAX) begin
      open_len += len;
    end else begin
      if (open_valid) flush_open();
      open_valid = 1'b1;
      open_type = ty;
      open_len = len;
      open_ref = r;
      open_seq = s;
    end
  endfunction

  // events caused by one accepted item
  function automatic void expand_item(cae_pkg::in_item_t it);
    int         n, i;
    logic [1:0] ty;
    item_events.delete();
    n = int'(it.op_length);
    if (n > cae_pkg::MAX_OP_LENGTH) n = cae_pkg::MAX_OP_LENGTH;
    case (it.req_type)
      cae_pkg::REQ_LDREF: ref_bases[cae_pkg::ref_addr_t'(it.addr)] = it.base;
      cae_pkg::REQ_LDQRY: qry_bases[cae_pkg::qry_addr_t'(it.addr)] = it.base;
      cae_pkg::REQ_START: begin
        align_off = it.ref_offset;
        ref_cur = '0;
        seq_cur = '0;
        open_valid = 1'b0;
        open_type = '0;
        open_len = 0;
        open_ref = '0;
        open_seq = '0;
      end
      cae_pkg::REQ_OP: begin
        if (n != 0) begin
          case (it.op_code)
            cae_pkg::OP_M, cae_pkg::OP_EQ, cae_pkg::OP_X: begin
              for (i = 0; i < n; i++) begin
                ty = (ref_bases[cae_pkg::ref_addr_t'(align_off + ref_cur)] ==
                      qry_bases[cae_pkg::qry_addr_t'(seq_cur)]) ?
                     cae_pkg::EV_MATCH : cae_pkg::EV_MISMATCH;
                note_event(ty, 1, ref_cur, seq_cur);
                ref_cur++;
                seq_cur++;
              end
            end
            cae_pkg::OP_I: begin
              note_event(cae_pkg::EV_INS, n, ref_cur, seq_cur);
              seq_cur += cae_pkg::pos_t'(n);
            end
            cae_pkg::OP_D: begin
              note_event(cae_pkg::EV_DEL, n, ref_cur, seq_cur);
              ref_cur += cae_pkg::pos_t'(n);
            end
            cae_pkg::OP_N: ref_cur += cae_pkg::pos_t'(n);
            cae_pkg::OP_S: seq_cur += cae_pkg::pos_t'(n);
            default: ;
          endcase
        end
      end
      cae_pkg::REQ_FINISH: begin
        if (open_valid) begin
          flush_open();
          open_type = '0;
          open_len = 0;
          open_ref = '0;
          open_seq = '0;
        end
      end
      default: ;
    endcase
    if (item_events.size() != 0) item_events[item_events.size()-1].last = 1'b1;
    for (i = 0; i < item_events.size(); i++) due_events = {due_events, item_events[i]};
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // driver: next item or a gap at the falling edge, once the current one is taken
  always @(negedge clk) begin : driver
    bit hold_off;
    hold_off = !(items_taken >= 150 && items_taken < 400) && ($urandom_range(99) < 24);
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (cigar_items.size() != 0 && !hold_off) begin
        request <= cigar_items.pop_front();
        start <= 1'b1;
      end else begin
        request <= random_item();
        start <= 1'b0;
      end
    end
  end

  // monitor: check strobed events, then expand the item taken at this edge
  always @(posedge clk) begin : monitor
    cae_pkg::out_item_t want;
    if (rst) begin
      took = 1'b0;
    end else begin
      if (result_valid) begin
        if (due_events.size() == 0) begin
          errors++;
          $display("%0t: event with none expected, actual type %0d length %0d ref %0d seq %0d",
                   $time, result.event_type, result.event_length, result.ref_pos,
                   result.seq_pos);
        end else begin
          want = due_events.pop_front();
          check_field("event_type", 16'(want.event_type), 16'(result.event_type));
          check_field("event_length", want.event_length, result.event_length);
          check_field("ref_pos", want.ref_pos, result.ref_pos);
          check_field("seq_pos", want.seq_pos, result.seq_pos);
          check_field("last", 16'(want.last), 16'(result.last));
          ev_count[want.event_type]++;
          events_checked++;
        end
      end
      took = start && !busy;
      if (took) begin
        expand_item(request);
        items_taken++;
      end
    end
  end

  // watchdog on cycles with no item taken and no event out
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || result_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d items left, %0d events due",
               $time, QUIET_LIMIT, cigar_items.size(), due_events.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    cae_pkg::in_item_t it;
    int                k, nops, pick, len, target;
    logic [3:0]        code, prev_code;
    logic [11:0]       off;

    gen_off = '0;
    gen_rc = '0;
    gen_sc = '0;
    prev_code = cae_pkg::OP_M;

    // directed: finish with nothing open, ignored request codes
    gen_finish();
    for (k = 1; k <= REQ_TOP - cae_pkg::REQ_FINISH; k++) begin
      it = random_item();
      it.req_type = cae_pkg::REQ_FINISH + 3'(k);
      queue_item(it);
    end
    // extreme bases and addresses, reference read wrapping past the store end
    gen_load_ref(12'hFFF, 8'hFF);
    gen_load_ref(12'h000, 8'h00);
    gen_load_qry(12'hFFF, 8'hFF);
    gen_start(12'hFFF);
    gen_op(cae_pkg::OP_M, 3);
    gen_op(cae_pkg::OP_M, 0);
    // adjacent insertions merge, then every other operation kind
    gen_op(cae_pkg::OP_I, cae_pkg::MAX_OP_LENGTH);
    gen_op(cae_pkg::OP_I, 1);
    gen_op(cae_pkg::OP_D, 5);
    gen_op(cae_pkg::OP_N, 2);
    gen_op(cae_pkg::OP_S, 3);
    gen_op(cae_pkg::OP_H, 10);
    gen_op(cae_pkg::OP_P, 10);
    gen_op(cae_pkg::OP_X + 4'd1, 7);
    gen_op(OP_LAST, 63);
    gen_op(cae_pkg::OP_EQ, 2);
    gen_op(cae_pkg::OP_X, 2);
    gen_op(cae_pkg::OP_D, cae_pkg::MAX_OP_LENGTH);
    gen_finish();
    gen_finish();
    // open event dropped by a new start
    gen_op(cae_pkg::OP_I, 4);
    gen_start(12'h000);
    gen_finish();

    // random alignments with stray loads and ignored requests mixed in
    target = stim_count + RANDOM_ITEMS;
    while (stim_count < target) begin
      pick = $urandom_range(9);
      if (pick < 4) off = gen_off;
      else if (pick < 6) off = 12'(cae_pkg::REF_DEPTH - $urandom_range(1, 40));
      else off = 12'($urandom_range(cae_pkg::REF_DEPTH - 1));
      gen_start(off);
      nops = $urandom_range(1, 8);
      for (k = 0; k < nops; k++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          gen_load_ref(12'($urandom), pick_base());
        end else if (pick < 6) begin
          gen_load_qry(12'($urandom), pick_base());
        end else if (pick < 9) begin
          it = random_item();
          it.req_type = cae_pkg::REQ_FINISH +
                        3'($urandom_range(1, REQ_TOP - cae_pkg::REQ_FINISH));
          queue_item(it);
        end
        pick = $urandom_range(99);
        if (pick < 10 && k != 0) code = prev_code;
        else if (pick < 32) code = cae_pkg::OP_M;
        else if (pick < 40) code = cae_pkg::OP_EQ;
        else if (pick < 48) code = cae_pkg::OP_X;
        else if (pick < 60) code = cae_pkg::OP_I;
        else if (pick < 72) code = cae_pkg::OP_D;
        else if (pick < 78) code = cae_pkg::OP_N;
        else if (pick < 84) code = cae_pkg::OP_S;
        else if (pick < 88) code = cae_pkg::OP_H;
        else if (pick < 92) code = cae_pkg::OP_P;
        else code = 4'($urandom_range(cae_pkg::OP_X + 4'd1, OP_LAST));
        pick = $urandom_range(99);
        if (pick < 6) len = 0;
        else if (pick < 16) len = $urandom_range(32, cae_pkg::MAX_OP_LENGTH);
        else len = $urandom_range(1, 16);
        gen_op(code, len);
        prev_code = code;
      end
      pick = $urandom_range(99);
      if (pick < 85) begin
        gen_finish();
      end else if (pick < 92) begin
        gen_finish();
        gen_finish();
      end
    end

    // reset, then run until all items are in and all events are out
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    while (cigar_items.size() != 0 || start || due_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items, %0d events checked", items_taken, events_checked);
    $display("match %0d, mismatch %0d, insertion %0d, deletion %0d",
             ev_count[cae_pkg::EV_MATCH], ev_count[cae_pkg::EV_MISMATCH],
             ev_count[cae_pkg::EV_INS], ev_count[cae_pkg::EV_DEL]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
design/cae_pkg.sv
design/cae_ram.sv
design/cae_front.sv
design/cae_queue.sv
design/cae_back.sv
design/cigar_alignment_event_expander_core.sv
tb/sv/cigar_alignment_event_expander_core_tb.sv
